[rtl/mpdc_pkg.sv]
// ----------------------------------------------------------------------------
// mpdc_pkg - shared widths for the multi-port discharge controller
// Field widths of the request and response beats and of the register port.
// ----------------------------------------------------------------------------
`default_nettype none

package mpdc_pkg;

	localparam int REQ_TYPE_W = 1;
	localparam int PORT_W     = 3;
	localparam int SAMPLE_W   = 12;
	localparam int MODE_W     = 2;
	localparam int PERIOD_W   = 10;
	localparam int HOLD_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 16;

endpackage

`default_nettype wire

[rtl/mpdc_req_if.sv]
// ----------------------------------------------------------------------------
// mpdc_req_if - request channel
// Valid/ready channel carrying one sample or one millisecond tick per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpdc_req_if
	import mpdc_pkg::*;
	;

	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [PORT_W-1:0]     port;
	logic [SAMPLE_W-1:0]   sample;

	modport source (output valid, output req_type, output port, output sample, input ready);
	modport sink   (input valid, input req_type, input port, input sample, output ready);

endinterface

`default_nettype wire

[rtl/mpdc_rsp_if.sv]
// ----------------------------------------------------------------------------
// mpdc_rsp_if - response channel
// Valid/ready channel carrying the port masks, fan and addressed port status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mpdc_rsp_if
	import mpdc_pkg::*;
	#(parameter int PORTS = 5);

	logic                valid;
	logic                ready;
	logic [PORTS-1:0]    gate_mask;
	logic [PORTS-1:0]    green_mask;
	logic                fan_on;
	logic [MODE_W-1:0]   port_mode;
	logic [SAMPLE_W-1:0] port_average;

	modport source (output valid, output gate_mask, output green_mask, output fan_on,
		output port_mode, output port_average, input ready);
	modport sink   (input valid, input gate_mask, input green_mask, input fan_on,
		input port_mode, input port_average, output ready);

endinterface

`default_nettype wire

[rtl/mpdc_ram.sv]
// ----------------------------------------------------------------------------
// mpdc_ram - generic simple dual-port RAM
// One write port, one read port with enable; read data registered and held.
// ----------------------------------------------------------------------------
`default_nettype none

module mpdc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/multi_port_discharge_controller.sv]
// ----------------------------------------------------------------------------
// multi_port_discharge_controller - battery storage discharge controller
// Rolling average per port, idle/discharging/done machine, gate and LED masks,
// blink timers and a fan hold-off timer.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-------------------------------------------
//  req     | in  | valid / ready  | req_type, port, sample
//  rsp     | out | valid / ready  | gate_mask, green_mask, fan_on,
//          |     |                | port_mode, port_average
//  cfg     | in  | cfg_we         | cfg_idx, cfg_data (write only)
//
//  A beat is accepted into stage 1, which issues the sample store read; the
//  commit then updates state and loads the result register. A new beat is
//  accepted every cycle while the result register is free or drains; each
//  beat waits in stage 1 for the registered read of the sample store RAM.
//  Reset clears all control state at once; the sample store needs no clearing
//  pass, since a per-port fill flag makes unwritten entries read as zero.
//  A stalled result holds the pipeline; req.ready drops only while rsp holds
//  an unaccepted beat that cannot advance.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_port_discharge_controller
	import mpdc_pkg::*;
	#(
	parameter int PORTS  = 5,
	parameter int WINDOW = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mpdc_req_if.sink                  req,
	mpdc_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int PIDX_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int DEPTH    = PORTS * WINDOW;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int SUM_W    = SAMPLE_W + SLOT_W;
	// floor(sum / WINDOW) as (sum * RECIP_M) >> RECIP_SH, exact for sum < 2**SUM_W
	localparam int RECIP_SH = SUM_W + SLOT_W;
	localparam int RECIP_M  = (2 ** RECIP_SH + WINDOW - 1) / WINDOW;
	localparam int PROD_W   = 2 * SUM_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_STORAGE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_FAN     = CFG_IDX_W'(3);

	localparam logic [REQ_TYPE_W-1:0] REQ_SAMPLE = REQ_TYPE_W'(0);
	localparam logic [REQ_TYPE_W-1:0] REQ_TICK   = REQ_TYPE_W'(1);

	localparam logic [SAMPLE_W-1:0] STORAGE_RST = SAMPLE_W'(3690);
	localparam logic [SAMPLE_W-1:0] EMPTY_RST   = SAMPLE_W'(2913);
	localparam logic [PERIOD_W-1:0] BLINK_RST   = PERIOD_W'(500);
	localparam logic [HOLD_W-1:0]   FAN_RST     = HOLD_W'(30000);

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE = 2'd0,
		MODE_DIS  = 2'd1,
		MODE_DONE = 2'd2
	} mode_t;

	// configuration registers
	logic [SAMPLE_W-1:0] storage_thr_q;
	logic [SAMPLE_W-1:0] empty_thr_q;
	logic [PERIOD_W-1:0] blink_period_q;
	logic [HOLD_W-1:0]   fan_hold_q;

	// per-port state
	logic [SLOT_W-1:0]   slot_q      [PORTS];
	logic                filled_q    [PORTS];
	logic [SUM_W-1:0]    sum_q       [PORTS];
	mode_t               mode_q      [PORTS];
	logic [PERIOD_W-1:0] blink_cnt_q [PORTS];
	logic                blink_lit_q [PORTS];

	// fan state
	logic              fan_q;
	logic              cooling_q;
	logic [HOLD_W-1:0] cool_cnt_q;

	// stage 1: accepted beat waiting for its store read
	logic                valid_s1;
	logic                tick_s1;
	logic                hit_s1;
	logic [PIDX_W-1:0]   pidx_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                filled_s1;

	// result register
	logic                rsp_valid_q;
	logic [PORTS-1:0]    gate_q;
	logic [PORTS-1:0]    green_q;
	logic [MODE_W-1:0]   pmode_q;
	logic [SAMPLE_W-1:0] pavg_q;

	// accept side
	logic              adv;
	logic              accept;
	logic              in_range;
	logic              acc_hit;
	logic [PIDX_W-1:0] acc_pidx;
	logic [SLOT_W-1:0] acc_slot;
	logic [SLOT_W-1:0] acc_slot_nx;
	logic [ADDR_W-1:0] acc_addr;
	logic              commit;

	// stage 1 datapath
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    new_sum;
	logic [PROD_W-1:0]   prod;
	logic [SAMPLE_W-1:0] avg;
	mode_t               cur_mode;
	mode_t               next_mode;
	mode_t               mode_nx      [PORTS];
	logic [PERIOD_W-1:0] blink_cnt_nx [PORTS];
	logic                blink_lit_nx [PORTS];
	logic [PORTS-1:0]    gate_nx;
	logic [PORTS-1:0]    green_nx;
	logic                any_dis;
	logic                fan_nx;
	logic                cooling_nx;
	logic [HOLD_W-1:0]   cool_cnt_nx;

	// ------------------------------------------------------------------
	// Handshake: advance whenever the result register is free or drains
	// ------------------------------------------------------------------
	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = adv;
	assign accept    = req.valid && adv;
	assign commit    = adv && valid_s1;

	assign in_range    = int'(req.port) < PORTS;
	assign acc_hit     = (req.req_type == REQ_SAMPLE) && in_range;
	assign acc_pidx    = in_range ? PIDX_W'(req.port) : '0;
	assign acc_slot    = slot_q[acc_pidx];
	assign acc_slot_nx = (int'(acc_slot) == WINDOW - 1) ? '0 : acc_slot + SLOT_W'(1);
	assign acc_addr    = ADDR_W'(int'(acc_pidx) * WINDOW + int'(acc_slot));

	// Sample store: read the slot being replaced at acceptance, write it at commit.
	mpdc_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (commit && hit_s1),
		.waddr (addr_s1),
		.wdata (sample_s1),
		.re    (accept && acc_hit),
		.raddr (acc_addr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1 datapath: running sum, average, mode machine, blink, fan
	// ------------------------------------------------------------------
	always_comb begin
		// an entry not yet written in this port's first pass counts as zero
		old_sample = filled_s1 ? ram_rdata : '0;
		new_sum    = sum_q[pidx_s1] - SUM_W'(old_sample) + SUM_W'(sample_s1);
		prod       = PROD_W'(new_sum) * PROD_W'(RECIP_M);
		avg        = prod[RECIP_SH +: SAMPLE_W];
		cur_mode   = mode_q[pidx_s1];

		next_mode = cur_mode;
		unique case (cur_mode)
			MODE_IDLE: begin
				if (avg > storage_thr_q) begin
					next_mode = MODE_DIS;
				end else if (avg > empty_thr_q) begin
					next_mode = MODE_DONE;
				end
			end
			MODE_DIS: begin
				if (avg <= empty_thr_q) begin
					next_mode = MODE_IDLE;
				end else if (avg <= storage_thr_q) begin
					next_mode = MODE_DONE;
				end
			end
			MODE_DONE: begin
				if (avg <= empty_thr_q) begin
					next_mode = MODE_IDLE;
				end
			end
			default: begin
				next_mode = cur_mode;
			end
		endcase
	end

	always_comb begin
		for (int p = 0; p < PORTS; p++) begin
			mode_nx[p]      = mode_q[p];
			blink_cnt_nx[p] = blink_cnt_q[p];
			blink_lit_nx[p] = blink_lit_q[p];
			if (hit_s1 && int'(pidx_s1) == p) begin
				mode_nx[p] = next_mode;
				// entering discharge restarts the blink dark
				if (cur_mode == MODE_IDLE && next_mode == MODE_DIS) begin
					blink_cnt_nx[p] = '0;
					blink_lit_nx[p] = 1'b0;
				end
			end else if (tick_s1 && mode_q[p] == MODE_DIS) begin
				blink_cnt_nx[p] = blink_cnt_q[p] + PERIOD_W'(1);
				if (blink_cnt_nx[p] >= blink_period_q) begin
					blink_lit_nx[p] = !blink_lit_q[p];
					blink_cnt_nx[p] = '0;
				end
			end
			gate_nx[p]  = (mode_nx[p] == MODE_DIS);
			green_nx[p] = (mode_nx[p] == MODE_DONE) ||
				((mode_nx[p] == MODE_DIS) && blink_lit_nx[p]);
		end
	end

	assign any_dis = |gate_nx;

	always_comb begin
		fan_nx      = fan_q;
		cooling_nx  = cooling_q;
		cool_cnt_nx = cool_cnt_q;
		if (any_dis) begin
			fan_nx     = 1'b1;
			cooling_nx = 1'b0;
		end else begin
			if (!cooling_q) begin
				cooling_nx  = 1'b1;
				cool_cnt_nx = '0;
			end else if (tick_s1 && cool_cnt_q != '1) begin
				cool_cnt_nx = cool_cnt_q + HOLD_W'(1);
			end
			// drop the fan once the hold-off has run out
			if (cool_cnt_nx >= fan_hold_q) begin
				fan_nx = 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			storage_thr_q  <= STORAGE_RST;
			empty_thr_q    <= EMPTY_RST;
			blink_period_q <= BLINK_RST;
			fan_hold_q     <= FAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_STORAGE: storage_thr_q  <= cfg_data[SAMPLE_W-1:0];
				CFG_EMPTY:   empty_thr_q    <= cfg_data[SAMPLE_W-1:0];
				CFG_BLINK:   blink_period_q <= cfg_data[PERIOD_W-1:0];
				CFG_FAN:     fan_hold_q     <= cfg_data[HOLD_W-1:0];
				default:     ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Write slot and fill flag advance at acceptance, so a beat for the
	// same port in the next cycle already sees the following slot.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORTS; p++) begin
				slot_q[p]   <= '0;
				filled_q[p] <= 1'b0;
			end
		end else if (accept && acc_hit) begin
			slot_q[acc_pidx] <= acc_slot_nx;
			if (int'(acc_slot) == WINDOW - 1) begin
				filled_q[acc_pidx] <= 1'b1;
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_s1   <= (req.req_type == REQ_TICK);
			hit_s1    <= acc_hit;
			pidx_s1   <= acc_pidx;
			sample_s1 <= req.sample;
			addr_s1   <= acc_addr;
			filled_s1 <= filled_q[acc_pidx];
		end
	end

	// ------------------------------------------------------------------
	// Commit: per-port and fan state move with the beat into the result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PORTS; p++) begin
				sum_q[p]       <= '0;
				mode_q[p]      <= MODE_IDLE;
				blink_cnt_q[p] <= '0;
				blink_lit_q[p] <= 1'b0;
			end
			fan_q      <= 1'b0;
			cooling_q  <= 1'b0;
			cool_cnt_q <= '0;
		end else if (commit) begin
			if (hit_s1) begin
				sum_q[pidx_s1] <= new_sum;
			end
			for (int p = 0; p < PORTS; p++) begin
				mode_q[p]      <= mode_nx[p];
				blink_cnt_q[p] <= blink_cnt_nx[p];
				blink_lit_q[p] <= blink_lit_nx[p];
			end
			fan_q      <= fan_nx;
			cooling_q  <= cooling_nx;
			cool_cnt_q <= cool_cnt_nx;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s1;
		end
	end

	// result register payload; ticks and out-of-range ports report zero status
	always_ff @(posedge clk) begin
		if (commit) begin
			gate_q  <= gate_nx;
			green_q <= green_nx;
			pmode_q <= hit_s1 ? MODE_W'(next_mode) : '0;
			pavg_q  <= hit_s1 ? avg : '0;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.gate_mask    = gate_q;
	assign rsp.green_mask   = green_q;
	assign rsp.fan_on       = fan_q;
	assign rsp.port_mode    = pmode_q;
	assign rsp.port_average = pavg_q;

endmodule

`default_nettype wire
